// ===== rtl/core/bsac_pkg.sv =====
package bsac_pkg;

  localparam int ValueW      = 8;
  localparam int CountW      = 30;
  localparam int DefMaxValue = 128;

  localparam logic [ValueW-1:0] MaxValueReset = 8'd128;
  localparam logic [CountW-1:0] Prime         = 30'd1000000007;

  typedef logic [CountW-1:0] count_t;

  typedef enum logic {
    StIdle,
    StSum
  } state_e;

  // control broadcast to every cell
  typedef struct packed {
    logic              load;   // item accepted this cycle
    logic              seed;   // item starts a new array
    logic              shift;  // row moves one cell toward cell 0
    logic [ValueW-1:0] m;      // effective max value
    logic [ValueW-1:0] given;  // given entry, 0 = unknown
  } ctrl_t;

  // (a + b) mod p, a and b below p
  function automatic count_t add2_mod(input count_t a, input count_t b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, Prime}) begin
      s = s - {1'b0, Prime};
    end
    return s[CountW-1:0];
  endfunction

  // (a + b + c) mod p, all below p
  function automatic count_t add3_mod(input count_t a, input count_t b, input count_t c);
    logic [CountW+1:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    if (s >= {1'b0, Prime, 1'b0}) begin
      s = s - {1'b0, Prime, 1'b0};
    end else if (s >= {2'b00, Prime}) begin
      s = s - {2'b00, Prime};
    end
    return s[CountW-1:0];
  endfunction

endpackage

// ===== rtl/core/bsac_cell.sv =====
module bsac_cell #(
  parameter int Idx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsac_pkg::ctrl_t    ctrl_i,
  input  bsac_pkg::count_t   left_i,
  input  bsac_pkg::count_t   right_i,
  output bsac_pkg::count_t   count_o
);

  localparam int V = Idx + 1;

  bsac_pkg::count_t count_q, count_d;
  logic in_range;
  logic keep;

  assign in_range = (V <= int'(ctrl_i.m));
  assign keep     = in_range &&
                    ((ctrl_i.given == '0) || (int'(ctrl_i.given) == V));
  assign count_o  = in_range ? count_q : '0;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.load) begin
      if (!keep) begin
        count_d = '0;
      end else if (ctrl_i.seed) begin
        count_d = bsac_pkg::count_t'(1);
      end else begin
        count_d = bsac_pkg::add3_mod(left_i, count_o, right_i);
      end
    end else if (ctrl_i.shift) begin
      count_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/core/bounded_step_array_count_dp_unit.sv =====
// channel   | dir | fields (low bit up)           | transaction when
// s_axis    | in  | tdata: value[7:0]; tlast=last | s_axis_tvalid & s_axis_tready
// m_axis    | out | tdata: count[29:0], pad 0     | m_axis_tvalid & m_axis_tready
// cfg       | in  | max_value[7:0]                | cfg_valid_i & cfg_ready_o
//
// A row of MAX_VALUE cells updates all counts in the same cycle: one item per
// cycle while idle. On tlast the row shifts into a mod-p accumulator, one cell per
// cycle, and the count leaves once all m cells are summed (m = effective
// max_value); no item is taken during that sweep.
// Reset clears the row and sets max_value to 128. A stalled count waits in the
// output register while the next array's items are taken.
module bounded_step_array_count_dp_unit #(
  parameter int MAX_VALUE = bsac_pkg::DefMaxValue
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // value[7:0]
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,   // count[29:0], zero pad
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bsac_pkg::ValueW-1:0] cfg_max_value_i
);

  bsac_pkg::state_e state_q, state_d;
  logic [bsac_pkg::ValueW-1:0] max_value_q;
  logic [bsac_pkg::ValueW-1:0] m;
  logic [bsac_pkg::ValueW-1:0] cnt_q, cnt_d;
  bsac_pkg::count_t acc_q, acc_d;
  bsac_pkg::count_t out_q, out_d;
  logic out_vld_q, out_vld_d;
  logic start_q, start_d;
  logic load;
  logic done;
  bsac_pkg::ctrl_t ctrl;
  bsac_pkg::count_t row [MAX_VALUE];

  assign m = (32'(max_value_q) > 32'(MAX_VALUE)) ? bsac_pkg::ValueW'(MAX_VALUE) : max_value_q;

  assign s_axis_tready = (state_q == bsac_pkg::StIdle);
  assign load          = s_axis_tvalid && s_axis_tready;
  assign done          = (cnt_q == m);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q};

  assign ctrl.load  = load;
  assign ctrl.seed  = start_q;
  assign ctrl.shift = (state_q == bsac_pkg::StSum) && !done;
  assign ctrl.m     = m;
  assign ctrl.given = s_axis_tdata;

  for (genvar i = 0; i < MAX_VALUE; i++) begin : g_cell
    bsac_pkg::count_t left, right;
    if (i == 0) begin : g_lo
      assign left = '0;
    end else begin : g_lo
      assign left = row[i-1];
    end
    if (i == MAX_VALUE - 1) begin : g_hi
      assign right = '0;
    end else begin : g_hi
      assign right = row[i+1];
    end
    bsac_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .count_o (row[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    start_d   = start_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      bsac_pkg::StIdle: begin
        if (load) begin
          start_d = s_axis_tlast;
          if (s_axis_tlast) begin
            state_d = bsac_pkg::StSum;
            cnt_d   = '0;
            acc_d   = '0;
          end
        end
      end
      bsac_pkg::StSum: begin
        if (done) begin
          if (!out_vld_q || m_axis_tready) begin
            out_d     = acc_q;
            out_vld_d = 1'b1;
            state_d   = bsac_pkg::StIdle;
          end
        end else begin
          acc_d = bsac_pkg::add2_mod(acc_q, row[0]);
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = bsac_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsac_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= bsac_pkg::MaxValueReset;
      cnt_q       <= '0;
      out_vld_q   <= 1'b0;
      start_q     <= 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_value_q <= cfg_max_value_i;
      end
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      start_q   <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

endmodule
